// ===== hw/rtl/hptc_pkg.sv =====
// Shared types, register indexes and 32-bit wrap-around arithmetic helpers.
package hptc_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_CAL_TEMP    = 3'd0;
	localparam logic [2:0] REG_CAL_PRESS_A = 3'd1;
	localparam logic [2:0] REG_CAL_PRESS_B = 3'd2;
	localparam logic [2:0] REG_CAL_PRESS_C = 3'd3;
	localparam logic [2:0] REG_CAL_HUMID   = 3'd4;

	localparam int DIV_BITS = 32;

	// word that rides along with a pressure division
	typedef struct packed {
		logic [26:0] temp;
		logic [16:0] hum;
		logic        bad;
		logic        big;
	} side_t;

	// low 32 bits of a product, same for signed and unsigned operands
	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = 64'(a) * 64'(b);
		return p[31:0];
	endfunction

	// arithmetic right shift of a 32-bit word
	function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx12(input logic [11:0] v);
		return {{20{v[11]}}, v};
	endfunction

	function automatic logic [31:0] sx8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

endpackage

// ===== hw/rtl/hptc_front.sv =====
// Fourteen-stage front: temperature, pressure terms up to the divide, and humidity.
module hptc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_v,
	input  logic [19:0]          raw_temperature,
	input  logic [19:0]          raw_pressure,
	input  logic [15:0]          raw_humidity,
	input  logic [47:0]          cal_temp,
	input  logic [47:0]          cal_press_a,
	input  logic [47:0]          cal_press_b,
	input  logic [63:0]          cal_humid,
	output logic                 out_v,
	output logic [31:0]          num,
	output logic [31:0]          dvs,
	output hptc_pkg::side_t      side
);

	// calibration fields
	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, h1, h2, h3, h4, h5, h6;
	assign t1 = {16'd0, cal_temp[15:0]};
	assign t2 = hptc_pkg::sx16(cal_temp[31:16]);
	assign t3 = hptc_pkg::sx16(cal_temp[47:32]);
	assign p1 = {16'd0, cal_press_a[15:0]};
	assign p2 = hptc_pkg::sx16(cal_press_a[31:16]);
	assign p3 = hptc_pkg::sx16(cal_press_a[47:32]);
	assign p4 = hptc_pkg::sx16(cal_press_b[15:0]);
	assign p5 = hptc_pkg::sx16(cal_press_b[31:16]);
	assign p6 = hptc_pkg::sx16(cal_press_b[47:32]);
	assign h1 = {24'd0, cal_humid[7:0]};
	assign h2 = hptc_pkg::sx16(cal_humid[23:8]);
	assign h3 = {24'd0, cal_humid[31:24]};
	assign h4 = hptc_pkg::sx12(cal_humid[43:32]);
	assign h5 = hptc_pkg::sx12(cal_humid[55:44]);
	assign h6 = hptc_pkg::sx8(cal_humid[63:56]);

	logic [13:0] v_s;

	logic [31:0] x1_s1, d_s1;
	logic [19:0] ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7, ap_s8;
	logic [15:0] ah_s1, ah_s2, ah_s3, ah_s4, ah_s5;
	logic [31:0] m1_s2, m2_s2;
	logic [31:0] ta_s3, m3_s3;
	logic [31:0] tf_s4;
	logic [26:0] temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10, temp_s11;
	logic [26:0] temp_s12, temp_s13, temp_s14;
	logic [31:0] pa_s5, ha_s5;
	logic [31:0] sq_s6, mp5_s6, mp2_s6, mh5_s6, mh6_s6, mh3_s6, hu_s6;
	logic [31:0] b1_s7, mp3_s7, mp5_s7, mp2_s7, hb_s7, hd1_s7, he_s7;
	logic [31:0] pb_s8, pa2_s8, hd2_s8, hb_s8;
	logic [31:0] a3_s9, num0_s9, hm_s9, hb_s9;
	logic [31:0] dv_s10, pn_s10, hd4_s10, hb_s10;
	logic        bad_s11, big_s11, bad_s12, big_s12, bad_s13, big_s13, bad_s14, big_s14;
	logic [31:0] n_s11, n_s12, n_s13, n_s14, dv_s11, dv_s12, dv_s13, dv_s14;
	logic [31:0] ha_s11, ha_s12, ha_s13, hsq_s12, hm1_s13;
	logic [16:0] hum_s14;

	// stage-14 humidity finish
	logic [31:0] hf;
	logic [31:0] hc;
	always_comb begin
		hf = ha_s13 - hptc_pkg::asr(hm1_s13, 4);
		if (hf[31]) begin
			hc = 32'd0;
		end else if (hf > 32'd419430400) begin
			hc = 32'd419430400;
		end else begin
			hc = hf;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[12:0], in_v};
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: temperature differences
			x1_s1 <= {15'd0, raw_temperature[19:3]} - {t1[30:0], 1'b0};
			d_s1  <= {16'd0, raw_temperature[19:4]} - t1;
			ap_s1 <= raw_pressure;
			ah_s1 <= raw_humidity;
			// s2
			m1_s2 <= hptc_pkg::mul32(x1_s1, t2);
			m2_s2 <= hptc_pkg::mul32(d_s1, d_s1);
			ap_s2 <= ap_s1;
			ah_s2 <= ah_s1;
			// s3
			ta_s3 <= hptc_pkg::asr(m1_s2, 11);
			m3_s3 <= hptc_pkg::mul32(hptc_pkg::asr(m2_s2, 12), t3);
			ap_s3 <= ap_s2;
			ah_s3 <= ah_s2;
			// s4: fine temperature
			tf_s4 <= ta_s3 + hptc_pkg::asr(m3_s3, 14);
			ap_s4 <= ap_s3;
			ah_s4 <= ah_s3;
			// s5: temperature result, offsets for pressure and humidity
			temp_s5 <= 27'(hptc_pkg::asr({tf_s4[29:0], 2'b00} + tf_s4 + 32'd128, 8));
			pa_s5   <= hptc_pkg::asr(tf_s4, 1) - 32'd64000;
			ha_s5   <= tf_s4 - 32'd76800;
			ap_s5   <= ap_s4;
			ah_s5   <= ah_s4;
			// s6: first products
			sq_s6   <= hptc_pkg::mul32(hptc_pkg::asr(pa_s5, 2), hptc_pkg::asr(pa_s5, 2));
			mp5_s6  <= hptc_pkg::mul32(pa_s5, p5);
			mp2_s6  <= hptc_pkg::mul32(p2, pa_s5);
			mh5_s6  <= hptc_pkg::mul32(h5, ha_s5);
			mh6_s6  <= hptc_pkg::mul32(ha_s5, h6);
			mh3_s6  <= hptc_pkg::mul32(ha_s5, h3);
			hu_s6   <= {2'b00, ah_s5, 14'd0} - {h4[11:0], 20'd0};
			ap_s6   <= ap_s5;
			temp_s6 <= temp_s5;
			// s7
			b1_s7   <= hptc_pkg::mul32(hptc_pkg::asr(sq_s6, 11), p6);
			mp3_s7  <= hptc_pkg::mul32(p3, hptc_pkg::asr(sq_s6, 13));
			mp5_s7  <= mp5_s6;
			mp2_s7  <= mp2_s6;
			hb_s7   <= hptc_pkg::asr(hu_s6 - mh5_s6 + 32'd16384, 15);
			hd1_s7  <= hptc_pkg::asr(mh6_s6, 10);
			he_s7   <= hptc_pkg::asr(mh3_s6, 11) + 32'd32768;
			ap_s7   <= ap_s6;
			temp_s7 <= temp_s6;
			// s8
			pb_s8   <= hptc_pkg::asr(b1_s7 + {mp5_s7[30:0], 1'b0}, 2) + {p4[15:0], 16'd0};
			pa2_s8  <= hptc_pkg::asr(hptc_pkg::asr(mp3_s7, 3) + hptc_pkg::asr(mp2_s7, 1), 18);
			hd2_s8  <= hptc_pkg::mul32(hd1_s7, he_s7);
			hb_s8   <= hb_s7;
			ap_s8   <= ap_s7;
			temp_s8 <= temp_s7;
			// s9
			a3_s9   <= hptc_pkg::mul32(32'd32768 + pa2_s8, p1);
			num0_s9 <= (32'd1048576 - {12'd0, ap_s8}) - hptc_pkg::asr(pb_s8, 12);
			hm_s9   <= hptc_pkg::mul32(hptc_pkg::asr(hd2_s8, 10) + 32'd2097152, h2);
			hb_s9   <= hb_s8;
			temp_s9 <= temp_s8;
			// s10: divisor and scaled numerator
			dv_s10   <= hptc_pkg::asr(a3_s9, 15);
			pn_s10   <= hptc_pkg::mul32(num0_s9, 32'd3125);
			hd4_s10  <= hptc_pkg::asr(hm_s9 + 32'd8192, 14);
			hb_s10   <= hb_s9;
			temp_s10 <= temp_s9;
			// s11: division setup
			bad_s11  <= (dv_s10 == 32'd0);
			big_s11  <= pn_s10[31];
			n_s11    <= pn_s10[31] ? pn_s10 : {pn_s10[30:0], 1'b0};
			dv_s11   <= dv_s10;
			ha_s11   <= hptc_pkg::mul32(hb_s10, hd4_s10);
			temp_s11 <= temp_s10;
			// s12
			hsq_s12  <= hptc_pkg::mul32(hptc_pkg::asr(ha_s11, 15), hptc_pkg::asr(ha_s11, 15));
			ha_s12   <= ha_s11;
			bad_s12  <= bad_s11;
			big_s12  <= big_s11;
			n_s12    <= n_s11;
			dv_s12   <= dv_s11;
			temp_s12 <= temp_s11;
			// s13
			hm1_s13  <= hptc_pkg::mul32(hptc_pkg::asr(hsq_s12, 7), h1);
			ha_s13   <= ha_s12;
			bad_s13  <= bad_s12;
			big_s13  <= big_s12;
			n_s13    <= n_s12;
			dv_s13   <= dv_s12;
			temp_s13 <= temp_s12;
			// s14: humidity clamp
			hum_s14  <= hc[28:12];
			bad_s14  <= bad_s13;
			big_s14  <= big_s13;
			n_s14    <= n_s13;
			dv_s14   <= dv_s13;
			temp_s14 <= temp_s13;
		end
	end

	assign out_v     = v_s[13];
	assign num       = n_s14;
	assign dvs       = dv_s14;
	assign side.temp = temp_s14;
	assign side.hum  = hum_s14;
	assign side.bad  = bad_s14;
	assign side.big  = big_s14;

endmodule

// ===== hw/rtl/hptc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side word.
module hptc_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [31:0]      num,
	input  logic [31:0]      dvs,
	input  hptc_pkg::side_t  side_in,
	output logic             out_v,
	output logic [31:0]      quo,
	output hptc_pkg::side_t  side_out
);

	localparam int N = hptc_pkg::DIV_BITS;

	logic [31:0]     rem_s  [0:N-1];
	logic [31:0]     num_s  [0:N-1];
	logic [31:0]     dvs_s  [0:N-1];
	logic [31:0]     quo_s  [0:N-1];
	hptc_pkg::side_t side_s [0:N-1];
	logic [N-1:0]    vld_s;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [31:0]     r_c, n_c, d_c, q_c;
		hptc_pkg::side_t s_c;
		logic            v_c;
		logic [32:0]     t;
		logic [32:0]     sub;

		if (k == 0) begin : g_first
			assign r_c = 32'd0;
			assign n_c = num;
			assign d_c = dvs;
			assign q_c = 32'd0;
			assign s_c = side_in;
			assign v_c = in_v;
		end else begin : g_next
			assign r_c = rem_s[k-1];
			assign n_c = num_s[k-1];
			assign d_c = dvs_s[k-1];
			assign q_c = quo_s[k-1];
			assign s_c = side_s[k-1];
			assign v_c = vld_s[k-1];
		end

		// shift in next numerator bit, trial subtract
		assign t   = {r_c, n_c[31]};
		assign sub = t - {1'b0, d_c};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= sub[32] ? t[31:0] : sub[31:0];
				num_s[k]  <= {n_c[30:0], 1'b0};
				dvs_s[k]  <= d_c;
				quo_s[k]  <= {q_c[30:0], ~sub[32]};
				side_s[k] <= s_c;
			end
		end
	end

	assign out_v    = vld_s[N-1];
	assign quo      = quo_s[N-1];
	assign side_out = side_s[N-1];

endmodule

// ===== hw/rtl/hptc_back.sv =====
// Three-stage pressure correction after the divide; holds the output word.
module hptc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [31:0]      quo,
	input  hptc_pkg::side_t  side,
	input  logic [47:0]      cal_press_c,
	output logic             out_v,
	output logic [26:0]      temp,
	output logic [31:0]      pres,
	output logic             bad,
	output logic [16:0]      hum
);

	logic [31:0] p7, p8, p9;
	assign p7 = hptc_pkg::sx16(cal_press_c[15:0]);
	assign p8 = hptc_pkg::sx16(cal_press_c[31:16]);
	assign p9 = hptc_pkg::sx16(cal_press_c[47:32]);

	logic [31:0] pq;
	assign pq = side.big ? {quo[30:0], 1'b0} : quo;

	logic [2:0]      v_s;
	logic [31:0]     pr_s1, sq_s1, m8_s1, pr_s2, m9_s2, bb_s2, pr_s3;
	hptc_pkg::side_t sd_s1, sd_s2, sd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[1:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: square and p8 product
			pr_s1 <= pq;
			sq_s1 <= hptc_pkg::mul32({3'd0, pq[31:3]}, {3'd0, pq[31:3]});
			m8_s1 <= hptc_pkg::mul32({2'd0, pq[31:2]}, p8);
			sd_s1 <= side;
			// s2: p9 product
			pr_s2 <= pr_s1;
			m9_s2 <= hptc_pkg::mul32(p9, {13'd0, sq_s1[31:13]});
			bb_s2 <= hptc_pkg::asr(m8_s1, 13);
			sd_s2 <= sd_s1;
			// s3: final sum, zero on bad divisor
			pr_s3 <= sd_s2.bad ? 32'd0
				: pr_s2 + hptc_pkg::asr(hptc_pkg::asr(m9_s2, 12) + bb_s2 + p7, 4);
			sd_s3 <= sd_s2;
		end
	end

	assign out_v = v_s[2];
	assign temp  = sd_s3.temp;
	assign pres  = pr_s3;
	assign bad   = sd_s3.bad;
	assign hum   = sd_s3.hum;

endmodule

// ===== hw/rtl/humidity_pressure_temp_compensation.sv =====
// Top level: calibration registers, front pipeline, divider and pressure back end.
// One raw temperature/pressure/humidity word is taken per cycle unless the pipeline
// holds; each word passes 14 front, 32 divider and 3 back stages, and the
// 32-stage restoring divider for pressure sets the depth. The whole pipeline advances
// together and holds while a finished word waits at the output, so throughput is one
// word per cycle when out_ready stays high. Calibration writes belong to idle periods.
module humidity_pressure_temp_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [19:0] raw_temperature,
	input  logic [19:0] raw_pressure,
	input  logic [15:0] raw_humidity,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [26:0] temperature_centi,
	output logic [31:0] pressure_pa,
	output logic        pressure_invalid,
	output logic [16:0] humidity_q10,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	logic [47:0] cal_temp_q, cal_press_a_q, cal_press_b_q, cal_press_c_q;
	logic [63:0] cal_humid_q;

	// calibration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q    <= '0;
			cal_press_a_q <= '0;
			cal_press_b_q <= '0;
			cal_press_c_q <= '0;
			cal_humid_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hptc_pkg::REG_CAL_TEMP:    cal_temp_q    <= cfg_wdata[47:0];
				hptc_pkg::REG_CAL_PRESS_A: cal_press_a_q <= cfg_wdata[47:0];
				hptc_pkg::REG_CAL_PRESS_B: cal_press_b_q <= cfg_wdata[47:0];
				hptc_pkg::REG_CAL_PRESS_C: cal_press_c_q <= cfg_wdata[47:0];
				hptc_pkg::REG_CAL_HUMID:   cal_humid_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline advance
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic            f_v, d_v;
	logic [31:0]     f_num, f_dvs, d_quo;
	hptc_pkg::side_t f_side, d_side;

	hptc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_v            (in_valid),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.raw_humidity    (raw_humidity),
		.cal_temp        (cal_temp_q),
		.cal_press_a     (cal_press_a_q),
		.cal_press_b     (cal_press_b_q),
		.cal_humid       (cal_humid_q),
		.out_v           (f_v),
		.num             (f_num),
		.dvs             (f_dvs),
		.side            (f_side)
	);

	hptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (f_v),
		.num      (f_num),
		.dvs      (f_dvs),
		.side_in  (f_side),
		.out_v    (d_v),
		.quo      (d_quo),
		.side_out (d_side)
	);

	hptc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_v        (d_v),
		.quo         (d_quo),
		.side        (d_side),
		.cal_press_c (cal_press_c_q),
		.out_v       (out_valid),
		.temp        (temperature_centi),
		.pres        (pressure_pa),
		.bad         (pressure_invalid),
		.hum         (humidity_q10)
	);

	// zero divisor forces zero pressure
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pressure_invalid |-> pressure_pa == 32'd0)
		else $error("invalid pressure word is not zero");

	// humidity clamp holds
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity_q10 <= 17'd102400)
		else $error("humidity beyond clamp");

	// a stalled pipeline keeps its output word
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(pressure_pa) && $stable(humidity_q10) && out_valid)
		else $error("output changed during stall");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the temperature, pressure and humidity compensation block.
module tb;

	localparam logic [2:0] REG_UNUSED = 3'd5;   // past the last register, writes are dropped
	localparam int DRAIN_CYCLES = 60;            // pipeline depth plus margin
	localparam int STALL_LIMIT  = 3000;

	typedef struct packed {
		logic [26:0] temp;
		logic [31:0] press;
		logic        press_bad;
		logic [16:0] hum;
	} comp_word_t;

	// expected compensated words, oldest first
	class comp_scoreboard;
		comp_word_t pending_words[$];
		int         fails;
		int         seen;

		function void note_word(comp_word_t w);
			pending_words.push_back(w);
		endfunction

		function void check_word(comp_word_t got);
			comp_word_t want;
			seen++;
			if (pending_words.size() == 0) begin
				$error("unexpected word: temp %0d press %0d", $signed(got.temp), got.press);
				fails++;
				return;
			end
			want = pending_words.pop_front();
			if (got.temp !== want.temp) begin
				$error("temperature_centi: expected %0d, actual %0d",
					$signed(want.temp), $signed(got.temp));
				fails++;
			end
			if (got.press !== want.press) begin
				$error("pressure_pa: expected %0d, actual %0d", want.press, got.press);
				fails++;
			end
			if (got.press_bad !== want.press_bad) begin
				$error("pressure_invalid: expected %0d, actual %0d", want.press_bad, got.press_bad);
				fails++;
			end
			if (got.hum !== want.hum) begin
				$error("humidity_q10: expected %0d, actual %0d", want.hum, got.hum);
				fails++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [19:0] raw_temperature;
	logic [19:0] raw_pressure;
	logic [15:0] raw_humidity;
	logic        out_valid;
	logic        out_ready;
	logic [26:0] temperature_centi;
	logic [31:0] pressure_pa;
	logic        pressure_invalid;
	logic [16:0] humidity_q10;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_wdata;

	// local copy of the calibration registers
	logic [47:0] cal_t, cal_pa, cal_pb, cal_pc;
	logic [63:0] cal_h;

	comp_scoreboard sb;
	bit  calm;       // no idling on either side
	int  sent;
	int  bad_press_cnt;
	int  stall_cnt;

	humidity_pressure_temp_compensation u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
		.raw_humidity(raw_humidity),
		.out_valid(out_valid), .out_ready(out_ready),
		.temperature_centi(temperature_centi), .pressure_pa(pressure_pa),
		.pressure_invalid(pressure_invalid), .humidity_q10(humidity_q10),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// sign-filling right shift, n in 1..31
	function automatic logic [31:0] shr_fill(logic [31:0] x, int unsigned n);
		return (x >> n) | (x[31] ? ~(32'hFFFF_FFFF >> n) : 32'h0);
	endfunction

	function automatic logic [31:0] s16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// 32-bit wrapping integer compensation of one raw word
	function automatic comp_word_t compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
		logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] h1, h2, h3, h4, h5, h6;
		logic [31:0] at, ap, ah, a, b, d, tf, tc, pr, sq, hm;
		logic        bad;
		comp_word_t  w;
		t1 = {16'h0, cal_t[15:0]};  t2 = s16(cal_t[31:16]);  t3 = s16(cal_t[47:32]);
		p1 = {16'h0, cal_pa[15:0]}; p2 = s16(cal_pa[31:16]); p3 = s16(cal_pa[47:32]);
		p4 = s16(cal_pb[15:0]);     p5 = s16(cal_pb[31:16]); p6 = s16(cal_pb[47:32]);
		p7 = s16(cal_pc[15:0]);     p8 = s16(cal_pc[31:16]); p9 = s16(cal_pc[47:32]);
		h1 = {24'h0, cal_h[7:0]};   h2 = s16(cal_h[23:8]);   h3 = {24'h0, cal_h[31:24]};
		h4 = {{20{cal_h[43]}}, cal_h[43:32]};
		h5 = {{20{cal_h[55]}}, cal_h[55:44]};
		h6 = {{24{cal_h[63]}}, cal_h[63:56]};
		at = {12'h0, rt}; ap = {12'h0, rp}; ah = {16'h0, rh};
		bad = 1'b0;

		// temperature and fine temperature
		a = shr_fill(((at >> 3) - (t1 << 1)) * t2, 11);
		d = (at >> 4) - t1;
		b = shr_fill(shr_fill(d * d, 12) * t3, 14);
		tf = a + b;
		tc = shr_fill(tf * 32'd5 + 32'd128, 8);

		// pressure
		a = shr_fill(tf, 1) - 32'd64000;
		sq = shr_fill(a, 2) * shr_fill(a, 2);
		b = shr_fill(sq, 11) * p6;
		b = b + ((a * p5) << 1);
		b = shr_fill(b, 2) + (p4 << 16);
		a = shr_fill(shr_fill(p3 * shr_fill(sq, 13), 3) + shr_fill(p2 * a, 1), 18);
		a = shr_fill((32'd32768 + a) * p1, 15);
		if (a == 32'h0) begin
			pr = 32'h0;
			bad = 1'b1;
		end else begin
			pr = ((32'd1048576 - ap) - shr_fill(b, 12)) * 32'd3125;
			if (pr < 32'h8000_0000)
				pr = (pr << 1) / a;
			else
				pr = (pr / a) << 1;
			a = shr_fill(p9 * (((pr >> 3) * (pr >> 3)) >> 13), 12);
			b = shr_fill((pr >> 2) * p8, 13);
			pr = pr + shr_fill(a + b + p7, 4);
		end

		// humidity, clamped before the final scale
		a = tf - 32'd76800;
		b = shr_fill((ah << 14) - (h4 << 20) - h5 * a + 32'd16384, 15);
		d = shr_fill(a * h6, 10);
		d = shr_fill(d * (shr_fill(a * h3, 11) + 32'd32768), 10) + 32'd2097152;
		d = shr_fill(d * h2 + 32'd8192, 14);
		a = b * d;
		sq = shr_fill(shr_fill(a, 15) * shr_fill(a, 15), 7);
		a = a - shr_fill(sq * h1, 4);
		if (a[31])
			a = 32'h0;
		if (a > 32'd419430400)
			a = 32'd419430400;
		hm = a >> 12;

		w.temp = tc[26:0];
		w.press = pr;
		w.press_bad = bad;
		w.hum = hm[16:0];
		return w;
	endfunction

	// register write, mirrored into the local copy
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			hptc_pkg::REG_CAL_TEMP:    cal_t  = val[47:0];
			hptc_pkg::REG_CAL_PRESS_A: cal_pa = val[47:0];
			hptc_pkg::REG_CAL_PRESS_B: cal_pb = val[47:0];
			hptc_pkg::REG_CAL_PRESS_C: cal_pc = val[47:0];
			hptc_pkg::REG_CAL_HUMID:   cal_h  = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_cal(logic [47:0] t, logic [47:0] pa, logic [47:0] pb,
			logic [47:0] pc, logic [63:0] h);
		write_reg(hptc_pkg::REG_CAL_TEMP, {16'h0, t});
		write_reg(hptc_pkg::REG_CAL_PRESS_A, {16'h0, pa});
		write_reg(hptc_pkg::REG_CAL_PRESS_B, {16'h0, pb});
		write_reg(hptc_pkg::REG_CAL_PRESS_C, {16'h0, pc});
		write_reg(hptc_pkg::REG_CAL_HUMID, h);
		write_reg(REG_UNUSED, {$urandom, $urandom});
	endtask

	// wait until every expected word is back and the pipe is empty
	task automatic drain();
		while (sb.pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// drive one raw word, with random gaps, until accepted
	task automatic send_word(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		raw_temperature <= rt;
		raw_pressure <= rp;
		raw_humidity <= rh;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic send_random(int n);
		int k;
		for (k = 0; k < n; k++)
			send_word(20'($urandom), 20'($urandom), 16'($urandom));
	endtask

	// extremes of every raw field, plus midpoint, typical and bit-pattern values
	task automatic send_corners();
		send_word(20'h0, 20'h0, 16'h0);
		send_word(20'hF_FFFF, 20'hF_FFFF, 16'hFFFF);
		send_word(20'h0, 20'hF_FFFF, 16'h0);
		send_word(20'hF_FFFF, 20'h0, 16'hFFFF);
		send_word(20'h8_0000, 20'h8_0000, 16'h8000);
		send_word(20'd519888, 20'd415148, 16'd27000);
		send_word(20'h7_FFFF, 20'h5_5555, 16'hAAAA);
	endtask

	// input-side sampling and output checking at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_word(compensate(raw_temperature, raw_pressure, raw_humidity));
		if (arst_n && out_valid && out_ready) begin
			if (pressure_invalid === 1'b1)
				bad_press_cnt++;
			sb.check_word({temperature_centi, pressure_pa, pressure_invalid, humidity_q10});
		end
	end

	// receiver back-pressure
	always @(negedge clk)
		out_ready <= calm || ($urandom_range(0, 99) >= 13);

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("Timeout: no progress for %0d cycles", STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int ph;
		sb = new();
		calm = 1'b0;
		sent = 0;
		bad_press_cnt = 0;
		stall_cnt = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		raw_temperature = '0;
		raw_pressure = '0;
		raw_humidity = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cal_t = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0; cal_h = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset calibration: zero divisor everywhere
		send_corners();
		idle_input();
		drain();

		// typical datasheet calibration
		load_cal({16'(-1000), 16'(26435), 16'(27504)},
			{16'(3024), 16'(-10685), 16'(36477)},
			{16'(-7), 16'(140), 16'(2855)},
			{16'(6000), 16'(-14600), 16'(15500)},
			{8'(30), 12'(50), 12'(313), 8'(0), 16'(362), 8'(75)});
		send_corners();
		send_random(150);
		idle_input();
		drain();

		// all ones, then most positive signed fields
		load_cal('1, '1, '1, '1, '1);
		send_corners();
		idle_input();
		drain();
		load_cal(48'h7FFF_7FFF_FFFF, 48'h7FFF_7FFF_FFFF, 48'h7FFF_7FFF_7FFF,
			48'h7FFF_7FFF_7FFF, 64'h7F7F_F7FF_FF7F_FFFF);
		send_corners();
		send_random(50);
		idle_input();
		drain();

		// random calibrations; one without idling, one with a zero P1
		for (ph = 0; ph < 8; ph++) begin
			load_cal(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
				48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
				{$urandom, $urandom});
			if (ph == 5)
				write_reg(hptc_pkg::REG_CAL_PRESS_A, {16'h0, cal_pa[47:16], 16'h0});
			calm = (ph == 3);
			send_random(110);
			idle_input();
			calm = 1'b0;
			drain();
		end

		$display("Covered %0d raw words over 12 calibration sets, %0d checked words,",
			sent, sb.seen);
		$display("%0d of them with a zero pressure divisor.", bad_press_cnt);
		if (sb.fails == 0 && sb.pending_words.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/hptc_pkg.sv
hw/rtl/hptc_front.sv
hw/rtl/hptc_div.sv
hw/rtl/hptc_back.sv
hw/rtl/humidity_pressure_temp_compensation.sv
tb/tb.sv
